/* sv/mlre_pkg.sv */
// Package for the moving linear-regression endpoint.
// Holds the register map, field widths and reset values; no dependencies.
`default_nettype none

package mlre_pkg;

  // Field widths of the stream payloads.
  localparam int SAMPLE_W = 32;
  localparam int WLEN_W   = 7;

  // Window depth default and the shortest usable window.
  localparam int DEF_MAX_WINDOW = 64;
  localparam int MIN_WINDOW     = 2;

  // Configuration register map (byte addresses).
  localparam int            PADDR_W          = 3;
  localparam logic [2:0]    ADDR_WINDOW_LEN  = 3'd0;
  localparam logic [6:0]    WINDOW_LEN_RESET = 7'd14;

endpackage : mlre_pkg

`default_nettype wire

/* sv/moving_linear_regression_endpoint.sv */
// Least-squares moving regression endpoint: sample window memory, running sums,
// numerator build and a restoring divider, all under one small sequencer.
// Depends on mlre_pkg.
//
// Each accepted item is one signed Q16.16 price sample. It is stored in a
// circular window memory, then the last N samples are read back newest first,
// one per cycle, while one adder pair forms the sum of samples and the
// weighted sum (the weighted sum is built as a sum of prefix sums, so no
// multiplier is needed in that loop). A multiply step and a subtract
// step form the numerator 6*Sxy - 2*(N+1)*Sy, and a restoring divider
// produces one quotient bit per cycle over NUM_W bits. s_tready stays low
// from the acceptance of an item until its result is loaded into the
// output register. The result waits there, so a new item is taken while the
// last result is still pending. The window memory needs no clearing pass:
// slots never written since reset are masked to zero by the fill count.
`default_nettype none

module moving_linear_regression_endpoint
  import mlre_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream. s_tdata: close_price[31:0].
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [SAMPLE_W-1:0]   s_tdata,
  // Output stream. m_tdata: regression_value[31:0]; m_tuser: window_full[0].
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [SAMPLE_W-1:0]        m_tdata,
  output logic                       m_tuser,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SY_W   = SAMPLE_W + CNT_W;
  localparam int SXY_W  = SAMPLE_W + 2 * CNT_W;
  localparam int PROD_W = SY_W + CNT_W + 2;
  localparam int NUM_W  = SXY_W + 4;
  localparam int DEN_W  = 2 * CNT_W + 1;
  localparam int BIT_W  = $clog2(NUM_W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]           state;
  logic [WLEN_W-1:0]    window_length;
  logic [PTR_W-1:0]     write_slot;
  logic [CNT_W-1:0]     samples_seen;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 pend;
  logic                 rd_live;
  logic [SAMPLE_W-1:0]  rd_data;
  logic [CNT_W-1:0]     n_reg;
  logic signed [SY_W-1:0]   sy;
  logic signed [SXY_W-1:0]  sxy;
  logic signed [SY_W-1:0]   sy_next;
  logic signed [PROD_W-1:0] prod;
  logic [DEN_W-1:0]     den;
  logic                 neg;
  logic [NUM_W-1:0]     quo;
  logic [DEN_W-1:0]     rem;
  logic [BIT_W-1:0]     bit_cnt;
  logic [SAMPLE_W-1:0]  mem [MAX_WINDOW];

  logic                 in_acc;
  logic                 issue;
  logic [CNT_W-1:0]     n_eff;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W:0]       rem_shift;
  logic [SAMPLE_W-1:0]  sat_value;
  logic                 out_free;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign issue    = (state == ST_LOOP) && (issue_cnt < n_reg);
  assign out_free = !m_tvalid || m_tready;

  // Effective window length, clamped to the supported range.
  always_comb begin
    if (window_length < WLEN_W'(MIN_WINDOW)) begin
      n_eff = CNT_W'(MIN_WINDOW);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = CNT_W'(window_length);
    end
  end

  // Configuration register write and readback.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW_LEN) begin
      window_length <= pwdata[WLEN_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_WINDOW_LEN) ? {{(32 - WLEN_W){1'b0}}, window_length} : 32'd0;

  // Window memory: one write port for new samples, one registered read port.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[write_slot] <= s_tdata;
    end
    if (issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Running sums: the weighted sum is the sum of the newest-first prefix sums.
  assign sy_next = rd_live ? sy + SY_W'($signed(rd_data)) : sy;

  // Numerator and divider step.
  assign num       = (NUM_W'(sxy) <<< 2) + (NUM_W'(sxy) <<< 1) - (NUM_W'(prod) <<< 1);
  assign rem_shift = {rem, quo[NUM_W-1]};

  // Truncated quotient, saturated to the sample range.
  always_comb begin
    if (!neg && quo > NUM_W'(32'h7FFF_FFFF)) begin
      sat_value = 32'h7FFF_FFFF;
    end else if (neg && quo > NUM_W'(33'h0_8000_0000)) begin
      sat_value = 32'h8000_0000;
    end else if (neg) begin
      sat_value = -quo[SAMPLE_W-1:0];
    end else begin
      sat_value = quo[SAMPLE_W-1:0];
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_slot   <= '0;
      samples_seen <= '0;
      m_tvalid     <= 1'b0;
      pend         <= 1'b0;
      issue_cnt    <= '0;
      bit_cnt      <= '0;
    end else begin
      // A taken result clears valid unless the next one is loaded in the same cycle.
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            rd_ptr     <= write_slot;
            write_slot <= (write_slot == PTR_W'(MAX_WINDOW - 1)) ? '0 : write_slot + 1'b1;
            if (samples_seen < CNT_W'(MAX_WINDOW)) begin
              samples_seen <= samples_seen + 1'b1;
            end
            n_reg     <= n_eff;
            issue_cnt <= '0;
            pend      <= 1'b0;
            sy        <= '0;
            sxy       <= '0;
            state     <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (issue) begin
            rd_live   <= CNT_W'(rd_ptr) < samples_seen;
            rd_ptr    <= (rd_ptr == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_ptr - 1'b1;
            issue_cnt <= issue_cnt + 1'b1;
          end
          pend <= issue;
          if (pend) begin
            sy  <= sy_next;
            sxy <= sxy + SXY_W'(sy_next);
            if (!issue) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod  <= sy * $signed({2'b00, n_reg} + (CNT_W + 2)'(1));
          den   <= DEN_W'(n_reg) * (DEN_W'(n_reg) + DEN_W'(1));
          state <= ST_SUB;
        end
        ST_SUB: begin
          neg     <= num[NUM_W-1];
          quo     <= num[NUM_W-1] ? -num : num;
          rem     <= '0;
          bit_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_shift >= {1'b0, den}) begin
            rem <= DEN_W'(rem_shift - {1'b0, den});
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            rem <= rem_shift[DEN_W-1:0];
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_W'(NUM_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= sat_value;
            m_tuser  <= samples_seen >= n_reg;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A new item is never taken in the cycle right after one was accepted.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while the previous one was still at work");

  // The read loop never runs past the window length.
  a_issue_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOP) |-> (issue_cnt <= n_reg))
    else $error("window read ran past the window length");

  // The fill count saturates at the window depth.
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    samples_seen <= CNT_W'(MAX_WINDOW))
    else $error("fill count beyond the window depth");

  // The divider remainder stays below the divisor.
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < den))
    else $error("divider remainder not below the divisor");

  // A result only appears after the divider has finished.
  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FIN))
    else $error("result shown without a finished division");

endmodule : moving_linear_regression_endpoint

`default_nettype wire

/* verif/moving_linear_regression_endpoint_test.sv */
// Self-checking testbench for the moving linear-regression endpoint.
// Holds a small scoreboard class with its own least-squares predictor and the top test module.
// Depends on mlre_pkg and moving_linear_regression_endpoint.

// Tracks the sample window, predicts the fitted value for every accepted item
// and compares each output item with the oldest prediction.
class regression_scoreboard;
  typedef struct {
    logic signed [31:0] value;
    logic               full;
  } fit_t;

  localparam int DEPTH = mlre_pkg::DEF_MAX_WINDOW;

  logic signed [mlre_pkg::SAMPLE_W-1:0] price_history[DEPTH];
  int                                   next_slot;
  int                                   fill_count;
  logic [mlre_pkg::WLEN_W-1:0]          window_len;
  fit_t                                 pending_fits[$];
  int                                   failures;

  function new();
    foreach (price_history[i]) price_history[i] = '0;
    next_slot  = 0;
    fill_count = 0;
    window_len = mlre_pkg::WINDOW_LEN_RESET;
    failures   = 0;
  endfunction

  function void set_window(logic [mlre_pkg::WLEN_W-1:0] len);
    window_len = len;
  endfunction

  // Window length actually used: the register clamped to the legal range.
  function int span();
    int n;
    n = int'(window_len);
    if (n < mlre_pkg::MIN_WINDOW) n = mlre_pkg::MIN_WINDOW;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // Store the new price and predict the fitted value at the newest point.
  function void note_sample(logic [31:0] raw);
    int     n;
    int     slot;
    longint y;
    longint sum_y;
    longint sum_xy;
    longint num;
    longint den;
    longint q;
    fit_t   fit;
    n = span();
    price_history[next_slot] = raw;
    next_slot = (next_slot + 1) % DEPTH;
    if (fill_count < DEPTH) fill_count++;
    sum_y  = 0;
    sum_xy = 0;
    // Walk newest (x = n) to oldest (x = 1); unwritten slots still hold zero.
    for (int k = 0; k < n; k++) begin
      slot   = (next_slot + 2 * DEPTH - 1 - k) % DEPTH;
      y      = longint'(price_history[slot]);
      sum_y  += y;
      sum_xy += longint'(n - k) * y;
    end
    num = 6 * sum_xy - 2 * longint'(n + 1) * sum_y;
    den = longint'(n) * longint'(n + 1);
    q   = num / den;
    if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
    if (q < -64'sh8000_0000) q = -64'sh8000_0000;
    fit.value = 32'(q);
    fit.full  = (fill_count >= n);
    pending_fits.push_back(fit);
  endfunction

  task report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    failures++;
  endtask

  // Compare one output item with the oldest prediction.
  task check_fit(logic [31:0] value, logic full);
    fit_t want;
    if (pending_fits.size() == 0) begin
      report_mismatch($sformatf("output item %h/%b with none expected", value, full));
    end else begin
      want = pending_fits.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("regression_value %h, expected %h", value, want.value));
      if (full !== want.full)
        report_mismatch($sformatf("window_full %b, expected %b", full, want.full));
    end
  endtask

  function int pending();
    return pending_fits.size();
  endfunction
endclass

module moving_linear_regression_endpoint_test;
  import mlre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 150;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;   // regression_value[31:0]
  logic                m_tuser;   // window_full[0]
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  regression_scoreboard sb = new();
  bit                   quiet_phase = 1'b0;
  int                   cycle_count = 0;
  int                   stall_left = 0;

  moving_linear_regression_endpoint DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side: random stalls on m_tready, none in quiet phases.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      stall_left = pick_idle() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Every output item is checked against the predicted fit.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) sb.check_fit(m_tdata, m_tuser);
  end

  // Offer one price item and wait until it is taken.
  task automatic send_sample(input logic [31:0] price);
    s_tvalid <= 1'b1;
    s_tdata  <= price;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(price);
  endtask

  // Optional gap after an item; valid stays high when there is none.
  task automatic sender_gap();
    int len;
    len = (quiet_phase || $urandom_range(0, 1) == 0) ? 0 : pick_idle();
    if (len > 0) begin
      s_tvalid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic [31:0] price);
    send_sample(price);
    sender_gap();
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // APB write of the window length; upper data bits may carry noise.
  task automatic write_window_length(input logic [WLEN_W-1:0] len, input bit noisy);
    logic [31:0] word;
    word = noisy ? $urandom : 32'd0;
    word[WLEN_W-1:0] = len;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW_LEN;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_window(len);
  endtask

  task automatic reconfigure(input logic [WLEN_W-1:0] len, input bit noisy);
    drain();
    write_window_length(len, noisy);
  endtask

  // Random price: full range, a small price-like value, or an extreme.
  function automatic logic [31:0] random_price();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  initial begin
    logic [WLEN_W-1:0] len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default window of 14, not yet full: extremes and bit patterns.
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
    send_item(32'h0000_0000);
    send_item(32'h0000_0001);
    send_item(32'hFFFF_FFFF);
    send_item(32'hAAAA_AAAA);
    send_item(32'h5555_5555);

    // Window of 3: the extrapolated fit saturates high, then low.
    reconfigure(7'd3, 1'b0);
    send_item(32'h8000_0000);
    send_item(32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
    send_item(32'h8000_0000);

    // Out-of-range lengths clamp; a long window is not full yet.
    reconfigure(7'd0, 1'b1);
    send_item(random_price());
    send_item(random_price());
    reconfigure(7'd127, 1'b0);
    send_item(random_price());
    send_item(random_price());
    send_item(random_price());
    reconfigure(7'd65, 1'b1);
    send_item(random_price());
    send_item(random_price());
    reconfigure(7'd1, 1'b0);
    send_item(random_price());
    send_item(random_price());

    // Random phases, each with its own window length and idling mode.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: len = 7'd2;
        1: len = 7'd64;
        default: len = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(2, 64));
      endcase
      reconfigure(len, 1'($urandom_range(0, 1)));
      quiet_phase = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_price());
    end
    quiet_phase = 1'b0;

    // Let the last results come out, then wait out the pipeline.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came", sb.pending()));
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
sv/mlre_pkg.sv
sv/moving_linear_regression_endpoint.sv
verif/moving_linear_regression_endpoint_test.sv
